[rtl/plti_pkg.sv]
package plti_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 256;
  localparam int DATA_W              = 32;
  localparam int STEP_W              = 31;
  localparam int Q_FRAC_BITS         = 16;
  localparam int ALPHA_W             = Q_FRAC_BITS + 1;
  localparam int Q_ONE               = 1 << Q_FRAC_BITS;

  // input action codes
  typedef enum logic [1:0] {
    ACT_APPEND  = 2'd0,
    ACT_STEP    = 2'd1,
    ACT_RESTART = 2'd2,
    ACT_CLEAR   = 2'd3
  } act_t;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_ORDER = 2'd2
  } stat_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_APPEND,
    ST_CTRL,
    ST_ADV,
    ST_QUERY,
    ST_CLAMP,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_RD,
    ST_DN_CMP,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_MUL,
    ST_FIN,
    ST_DONE
  } state_t;

  // saturate a 33-bit signed sum to 32 bits
  function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W:0] s);
    logic [DATA_W-1:0] r;
    unique case (s[DATA_W:DATA_W-1])
      2'b01:   r = {1'b0, {(DATA_W-1){1'b1}}};
      2'b10:   r = {1'b1, {(DATA_W-1){1'b0}}};
      default: r = s[DATA_W-1:0];
    endcase
    return r;
  endfunction

endpackage

[rtl/piecewise_linear_table_interpolator_core.sv]
// channel | direction | handshake            | payload
// --------+-----------+----------------------+------------------------------------------
// in      | input     | in_valid / in_stall  | in_action, in_sample_time, in_sample_value,
//         |           |                      | in_step_size
// out     | output    | out_valid / out_stall| out_value, out_status
// cfg     | input     | cfg_wr_en            | cfg_wr_data (time offset)
//
// append, restart, clear: action state, then result state; empty-table step: result state;
// clamped step: advance, query, clamp; a lookup step also walks entries one by one
// on the single memory read port, then the 17-step divider, multiply and final add.
// one item at a time: in_stall is high from accept until the result is in the output register.
// a held result does not block the next accept; that item waits at its end for the register.
// rst_n is synchronous; no memory clearing pass, samples are read only below the entry count.
module piecewise_linear_table_interpolator_core #(
  parameter int TABLE_DEPTH = plti_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_action,
  input  logic [plti_pkg::DATA_W-1:0]  in_sample_time,
  input  logic [plti_pkg::DATA_W-1:0]  in_sample_value,
  input  logic [plti_pkg::STEP_W-1:0]  in_step_size,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [plti_pkg::DATA_W-1:0]  out_value,
  output logic [1:0]                   out_status,
  input  logic                         cfg_wr_en,
  input  logic [plti_pkg::DATA_W-1:0]  cfg_wr_data
);
  import plti_pkg::*;

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int MEM_W  = 2 * DATA_W;
  localparam int PROD_W = DATA_W + 1 + ALPHA_W + 1;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

  state_t state_r, state_nxt;

  // latched beat
  act_t               act_r;
  logic signed [31:0] st_r, sv_r;
  logic [STEP_W-1:0]  step_r;

  // block state
  logic [CNT_W-1:0]   cnt_r;
  logic signed [31:0] model_r;
  logic [ADDR_W-1:0]  search_r;
  logic signed [31:0] held_r;
  logic signed [31:0] offset_r;
  logic signed [31:0] first_time_r, first_value_r, last_time_r, last_value_r;

  // lookup working registers
  logic signed [31:0] q_r, t0_r, t1_r, v0_r, v1_r;
  logic [ADDR_W-1:0]  idx_r;
  logic signed [DATA_W:0]   diff_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [1:0]         status_r;

  logic               out_valid_r;
  logic [DATA_W-1:0]  out_value_r;
  logic [1:0]         out_status_r;

  // control outputs
  logic               in_stall_c;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [MEM_W-1:0]   ram_rdata;
  logic               div_start;
  logic               div_done;
  logic [ALPHA_W-1:0] div_quo;
  logic               out_load;

  // datapath helpers
  logic               append_full, append_order;
  logic signed [31:0] rd_time, rd_value;
  logic [CNT_W-1:0]   idx_lim;
  logic [ADDR_W-1:0]  idx_start;
  logic               walk_up, walk_down;
  logic [DATA_W-1:0]  div_num, div_span;
  logic signed [PROD_W-1:0] prod_nxt, prod_adj, prod_scaled;
  logic signed [31:0] fin_val;

  assign rd_time  = ram_rdata[MEM_W-1:DATA_W];
  assign rd_value = ram_rdata[DATA_W-1:0];

  assign append_full  = cnt_r == FULL_CNT;
  assign append_order = (cnt_r != '0) && (st_r <= last_time_r);

  assign idx_lim   = cnt_r - CNT_W'(2);
  assign idx_start = (CNT_W'(search_r) > idx_lim) ? idx_lim[ADDR_W-1:0] : search_r;

  assign walk_up   = q_r > rd_time;
  assign walk_down = (idx_r != '0) && (q_r < rd_time);

  assign div_num  = q_r - t0_r;
  assign div_span = t1_r - t0_r;

  // interpolation: v0 + (v1 - v0) * alpha / 2^16, truncated toward zero
  assign prod_nxt    = diff_r * $signed({1'b0, div_quo});
  assign prod_adj    = prod_r[PROD_W-1] ? prod_r + PROD_W'(Q_ONE - 1) : prod_r;
  assign prod_scaled = prod_adj >>> Q_FRAC_BITS;
  assign fin_val     = v0_r + prod_scaled[DATA_W-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (act_t'(in_action))
            ACT_APPEND:  state_nxt = ST_APPEND;
            ACT_STEP:    state_nxt = (cnt_r != '0) ? ST_ADV : ST_DONE;
            ACT_RESTART: state_nxt = ST_CTRL;
            ACT_CLEAR:   state_nxt = ST_CTRL;
            default:     state_nxt = ST_CTRL;
          endcase
        end
      end
      ST_APPEND:   state_nxt = ST_DONE;
      ST_CTRL:     state_nxt = ST_DONE;
      ST_ADV:      state_nxt = ST_QUERY;
      ST_QUERY:    state_nxt = ST_CLAMP;
      ST_CLAMP: begin
        if (q_r <= first_time_r || q_r >= last_time_r) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_UP_RD;
        end
      end
      ST_UP_RD:    state_nxt = ST_UP_CMP;
      ST_UP_CMP:   state_nxt = walk_up ? ST_UP_RD : ST_DN_RD;
      ST_DN_RD:    state_nxt = ST_DN_CMP;
      ST_DN_CMP:   state_nxt = walk_down ? ST_DN_RD : ST_DIV_GO;
      ST_DIV_GO:   state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: state_nxt = div_done ? ST_MUL : ST_DIV_WAIT;
      ST_MUL:      state_nxt = ST_FIN;
      ST_FIN:      state_nxt = ST_DONE;
      ST_DONE:     state_nxt = (!out_valid_r || !out_stall) ? ST_IDLE : ST_DONE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall_c = state_r != ST_IDLE;
    ram_we     = (state_r == ST_APPEND) && !append_full && !append_order;
    ram_raddr  = (state_r == ST_UP_RD) ? idx_r + ADDR_W'(1) : idx_r;
    div_start  = state_r == ST_DIV_GO;
    out_load   = (state_r == ST_DONE) && (!out_valid_r || !out_stall);
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // time offset register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
    end else if (cfg_wr_en) begin
      offset_r <= cfg_wr_data;
    end
  end

  // beat capture
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      act_r  <= act_t'(in_action);
      st_r   <= in_sample_time;
      sv_r   <= in_sample_value;
      step_r <= in_step_size;
    end
  end

  // table bookkeeping, model time, held output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      model_r  <= '0;
      search_r <= '0;
      held_r   <= '0;
      status_r <= STAT_OK;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          status_r <= STAT_OK;
        end
        ST_APPEND: begin
          if (append_full) begin
            status_r <= STAT_FULL;
          end else if (append_order) begin
            status_r <= STAT_ORDER;
          end else begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
        ST_CTRL: begin
          search_r <= '0;
          if (act_r == ACT_RESTART) begin
            model_r <= '0;
            held_r  <= (cnt_r != '0) ? first_value_r : '0;
          end else begin
            cnt_r <= '0;
          end
        end
        ST_ADV: begin
          model_r <= sat_add({model_r[31], model_r} + {2'b00, step_r});
        end
        ST_CLAMP: begin
          if (q_r <= first_time_r) begin
            held_r <= first_value_r;
          end else if (q_r >= last_time_r) begin
            held_r <= last_value_r;
          end
        end
        ST_DN_CMP: begin
          if (!walk_down) begin
            search_r <= idx_r;
          end
        end
        ST_FIN: begin
          held_r <= fin_val;
        end
        default: begin
        end
      endcase
    end
  end

  // end samples kept in registers for clamps and the order check
  always_ff @(posedge clk) begin
    if (ram_we) begin
      last_time_r  <= st_r;
      last_value_r <= sv_r;
      if (cnt_r == '0) begin
        first_time_r  <= st_r;
        first_value_r <= sv_r;
      end
    end
  end

  // search and interpolation working registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_QUERY: q_r <= sat_add({model_r[31], model_r} + {offset_r[31], offset_r});
      ST_CLAMP: idx_r <= idx_start;
      ST_UP_CMP: begin
        if (walk_up) begin
          idx_r <= idx_r + ADDR_W'(1);
        end else begin
          t1_r <= rd_time;
          v1_r <= rd_value;
        end
      end
      ST_DN_CMP: begin
        if (walk_down) begin
          t1_r  <= rd_time;
          v1_r  <= rd_value;
          idx_r <= idx_r - ADDR_W'(1);
        end else begin
          t0_r <= rd_time;
          v0_r <= rd_value;
        end
      end
      ST_DIV_GO: diff_r <= {v1_r[31], v1_r} - {v0_r[31], v0_r};
      ST_MUL:    prod_r <= prod_nxt;
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r  <= held_r;
      out_status_r <= status_r;
    end
  end

  // sample memory: {time, value} per entry
  plti_ram #(
    .WIDTH (MEM_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[ADDR_W-1:0]),
    .wdata ({st_r, sv_r}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // fraction divider
  plti_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_span),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign in_stall   = in_stall_c;
  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

  // entry count never passes the table size
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("entry count beyond table depth");

  // upward walk reads only entries below the count
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_UP_RD |-> (CNT_W'(idx_r) + CNT_W'(1)) < cnt_r)
    else $error("search read past last entry");

  // search ends with the query bracketed by an ordered pair
  a_bracket: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV_GO |-> (t0_r < t1_r && t0_r <= q_r && q_r <= t1_r))
    else $error("search did not bracket the query");

  // a new result beat only comes from the final state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("result beat raised outside final state");

endmodule

[rtl/plti_ram.sv]
module plti_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/plti_div.sv]
module plti_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [plti_pkg::DATA_W-1:0]   dividend,
  input  logic [plti_pkg::DATA_W-1:0]   divisor,
  output logic                          done,
  output logic [plti_pkg::ALPHA_W-1:0]  quotient
);
  import plti_pkg::*;

  localparam int CNT_W = $clog2(ALPHA_W + 1);

  // dividend <= divisor, so the quotient of (dividend << 16) fits in 17 bits;
  // the remainder starts at dividend >> 1 and its low bit is shifted in first
  logic [DATA_W:0]    rem_r, rem_nxt;
  logic [DATA_W-1:0]  dsr_r;
  logic [ALPHA_W-1:0] quo_r, quo_nxt;
  logic               lsb_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;
  logic               done_r;
  logic [DATA_W:0]    shifted;
  logic               fits;

  // one restoring step per cycle
  always_comb begin
    shifted = {rem_r[DATA_W-1:0], lsb_r};
    fits    = shifted >= {1'b0, dsr_r};
    rem_nxt = fits ? shifted - {1'b0, dsr_r} : shifted;
    quo_nxt = {quo_r[ALPHA_W-2:0], fits};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(ALPHA_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {2'b00, dividend[DATA_W-1:1]};
      lsb_r <= dividend[0];
      dsr_r <= divisor;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      lsb_r <= 1'b0;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
